// File: hdl/assert_macros.svh
// assertion macros used by usable_page_translator.sv
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define UVPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UVPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define UVPT_ASSERT(lbl, prop, msg)
`define UVPT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/uvpt_pkg.sv
// shared types, widths and codes of the usable page translator
// no dependencies
package uvpt_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int FRAME_W     = 40;
    localparam int ADDR_W      = 52;
    localparam int PAGE_SHIFT  = 12;
    localparam int ACC_W       = FRAME_W + 8;
    localparam int CFG_W       = 7;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_TO_ADDR = 2'd1;
    localparam logic [1:0] OP_TO_PAGE = 2'd2;
    localparam logic [1:0] OP_TOTAL   = 2'd3;

    localparam logic [7:0] TYPE_USABLE_A = 8'd1;
    localparam logic [7:0] TYPE_USABLE_B = 8'd2;
    localparam logic [7:0] TYPE_USABLE_C = 8'd3;
    localparam logic [7:0] TYPE_USABLE_D = 8'd4;
    localparam logic [7:0] TYPE_USABLE_E = 8'd7;

    typedef struct packed {
        logic               usable;
        logic [FRAME_W-1:0] start_frame;
        logic [FRAME_W-1:0] pages;
    } t_entry;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    function automatic logic type_usable(input logic [7:0] t);
        return (t == TYPE_USABLE_A) || (t == TYPE_USABLE_B) || (t == TYPE_USABLE_C) ||
               (t == TYPE_USABLE_D) || (t == TYPE_USABLE_E);
    endfunction

endpackage

// File: hdl/uvpt_table.sv
// region table: one write port, one registered read port
// depends on uvpt_pkg
module uvpt_table (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [uvpt_pkg::IDX_W-1:0] i_wr_addr,
    input  uvpt_pkg::t_entry        i_wr_data,
    input  logic                    i_rd_en,
    input  logic [uvpt_pkg::IDX_W-1:0] i_rd_addr,
    output uvpt_pkg::t_entry        o_rd_data
);
    import uvpt_pkg::*;

    t_entry r_mem [MAX_REGIONS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/uvpt_alu.sv
// shared add / subtract unit with borrow flag
// depends on uvpt_pkg
module uvpt_alu (
    input  uvpt_pkg::t_alu_req i_req,
    output uvpt_pkg::t_alu_rsp o_rsp
);
    import uvpt_pkg::*;

    logic [ACC_W:0] sum;

    always_comb begin
        sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
            + {{ACC_W{1'b0}}, i_req.sub};
        o_rsp.res    = sum[ACC_W-1:0];
        o_rsp.borrow = i_req.sub & ~sum[ACC_W];
    end

endmodule

// File: hdl/usable_page_translator.sv
// usable page translator top level: sequencer walking the region table
// depends on uvpt_pkg, uvpt_table, uvpt_alu and assert_macros.svh
//
// channel   direction  handshake            payload
// command   in         start && !busy       i_opcode .. i_address
// result    out        o_valid, one cycle   o_found .. o_total_usable_pages
// config    in         i_cfg_we             i_cfg_wdata (region_count)
//
// a region write or a misaligned address query answers in the cycle after it is taken
// a walk reads each slot (ST_RD) and evaluates it (ST_EV); for address queries a
// usable slot may also pass ST_E2 and ST_ADV, and the walk ends in ST_F1 or ST_RD
// the single table read port and the shared adder set that sequence of states
// synchronous active-low reset clears control state; table is undefined
// results cannot be stalled; a new command is taken in the result cycle
`include "assert_macros.svh"

module usable_page_translator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_opcode,
    input  logic [5:0]                   i_region_index,
    input  logic [7:0]                   i_region_type,
    input  logic [51:0]                  i_region_start,
    input  logic [39:0]                  i_region_pages,
    input  logic [39:0]                  i_page_number,
    input  logic [51:0]                  i_address,
    input  logic                         i_cfg_we,
    input  logic [uvpt_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [51:0]                  o_result_address,
    output logic [39:0]                  o_result_page_number,
    output logic [39:0]                  o_total_usable_pages
);
    import uvpt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_E2   = 3'd3;
    localparam logic [2:0] ST_ADV  = 3'd4;
    localparam logic [2:0] ST_F1   = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CFG_W-1:0]   r_rc;
    logic [ACC_W-1:0]   r_rem, n_rem;
    logic [FRAME_W-1:0] r_fr, n_fr;
    logic [ACC_W-1:0]   r_cur, n_cur;
    logic [ACC_W-1:0]   r_d, n_d;
    logic               r_o_valid, n_o_valid;
    logic               r_o_found, n_o_found;
    logic [ADDR_W-1:0]  r_o_addr, n_o_addr;
    logic [FRAME_W-1:0] r_o_page, n_o_page;
    logic [FRAME_W-1:0] r_o_total, n_o_total;

    logic               accept;
    logic               wr_ok;
    logic [CNT_W-1:0]   walk_len;
    logic               fits;
    t_entry             wr_entry;
    t_entry             ent;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_ok  = (CNT_W'(i_region_index) < CNT_W'(MAX_REGIONS));

    assign walk_len = (CNT_W'(r_rc) > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS)
                                                           : CNT_W'(r_rc);

    assign wr_entry.usable      = type_usable(i_region_type);
    assign wr_entry.start_frame = i_region_start[ADDR_W-1:PAGE_SHIFT];
    assign wr_entry.pages       = i_region_pages;

    uvpt_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_opcode == OP_WRITE) && wr_ok),
        .i_wr_addr (IDX_W'(i_region_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (ent)
    );

    uvpt_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign fits = (alu_rsp.res[ACC_W-1:FRAME_W] == '0);

    // operand select for the shared adder
    always_comb begin
        alu_req = '0;
        case (r_state)
            ST_EV: begin
                case (r_op)
                    OP_TO_ADDR: alu_req = '{a: r_rem, b: ACC_W'(ent.pages), sub: 1'b1};
                    OP_TO_PAGE: alu_req = '{a: ACC_W'(r_fr), b: ACC_W'(ent.start_frame),
                                            sub: 1'b1};
                    default:    alu_req = '{a: r_cur, b: ACC_W'(ent.pages), sub: 1'b0};
                endcase
            end
            ST_E2:  alu_req = '{a: r_d, b: ACC_W'(ent.pages), sub: 1'b1};
            ST_ADV: alu_req = '{a: r_cur, b: ACC_W'(ent.pages), sub: 1'b0};
            ST_F1: begin
                if (r_op == OP_TO_ADDR) begin
                    alu_req = '{a: ACC_W'(ent.start_frame), b: r_rem, sub: 1'b0};
                end else begin
                    alu_req = '{a: r_cur, b: r_d, sub: 1'b0};
                end
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_len     = r_len;
        n_rem     = r_rem;
        n_fr      = r_fr;
        n_cur     = r_cur;
        n_d       = r_d;
        n_o_valid = 1'b0;
        n_o_found = r_o_found;
        n_o_addr  = r_o_addr;
        n_o_page  = r_o_page;
        n_o_total = r_o_total;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op  = i_opcode;
                    n_idx = '0;
                    n_len = walk_len;
                    n_rem = ACC_W'(i_page_number);
                    n_fr  = i_address[ADDR_W-1:PAGE_SHIFT];
                    n_cur = '0;
                    if (i_opcode == OP_WRITE) begin
                        n_o_valid = 1'b1;
                        n_o_found = wr_ok;
                        n_o_addr  = '0;
                        n_o_page  = '0;
                        n_o_total = '0;
                    end else if ((i_opcode == OP_TO_PAGE) &&
                                 (i_address[PAGE_SHIFT-1:0] != '0)) begin
                        n_o_valid = 1'b1;
                        n_o_found = 1'b0;
                        n_o_addr  = '0;
                        n_o_page  = '0;
                        n_o_total = '0;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                if (r_idx == r_len) begin
                    // walk ran out without a hit
                    n_o_valid = 1'b1;
                    n_o_found = (r_op == OP_TOTAL);
                    n_o_addr  = '0;
                    n_o_page  = '0;
                    if (r_op == OP_TOTAL) begin
                        n_o_total = (r_cur[ACC_W-1:FRAME_W] != '0) ? '1
                                                                    : r_cur[FRAME_W-1:0];
                    end else begin
                        n_o_total = '0;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EV;
                end
            end
            ST_EV: begin
                if (!ent.usable) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RD;
                end else begin
                    case (r_op)
                        OP_TO_ADDR: begin
                            if (alu_rsp.borrow) begin
                                n_state = ST_F1;
                            end else begin
                                n_rem   = alu_rsp.res;
                                n_idx   = r_idx + 1'b1;
                                n_state = ST_RD;
                            end
                        end
                        OP_TO_PAGE: begin
                            if (alu_rsp.borrow) begin
                                n_state = ST_ADV;
                            end else begin
                                n_d     = alu_rsp.res;
                                n_state = ST_E2;
                            end
                        end
                        default: begin
                            n_cur   = alu_rsp.res;
                            n_idx   = r_idx + 1'b1;
                            n_state = ST_RD;
                        end
                    endcase
                end
            end
            ST_E2: begin
                n_state = alu_rsp.borrow ? ST_F1 : ST_ADV;
            end
            ST_ADV: begin
                n_cur   = alu_rsp.res;
                n_idx   = r_idx + 1'b1;
                n_state = ST_RD;
            end
            ST_F1: begin
                n_o_valid = 1'b1;
                n_o_found = fits;
                n_o_total = '0;
                if (r_op == OP_TO_ADDR) begin
                    n_o_addr = fits ? {alu_rsp.res[FRAME_W-1:0], {PAGE_SHIFT{1'b0}}} : '0;
                    n_o_page = '0;
                end else begin
                    n_o_addr = '0;
                    n_o_page = fits ? alu_rsp.res[FRAME_W-1:0] : '0;
                end
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_len     <= '0;
            r_rc      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_rc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_rem     <= n_rem;
        r_fr      <= n_fr;
        r_cur     <= n_cur;
        r_d       <= n_d;
        r_o_found <= n_o_found;
        r_o_addr  <= n_o_addr;
        r_o_page  <= n_o_page;
        r_o_total <= n_o_total;
    end

    assign o_valid              = r_o_valid;
    assign o_found              = r_o_found;
    assign o_result_address     = r_o_addr;
    assign o_result_page_number = r_o_page;
    assign o_total_usable_pages = r_o_total;

    `UVPT_ASSERT(a_word_has_cause, o_valid |-> $past(busy || start), "result word without a command")
    `UVPT_ASSERT(a_walk_goes_busy, (accept && (i_opcode == OP_TO_ADDR)) |=> busy, "walk did not start")
    `UVPT_ASSERT(a_idx_in_walk, busy |-> (r_idx <= r_len), "slot index ran past walk length")
    `UVPT_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "result word right after reset")

endmodule
